/* hdl/sclu_pkg.sv */
// Shared types and constants for the shell command lexer unit.
// Depends on nothing. It is used by every module of the block.
package sclu_pkg;

  // Input transaction: one byte, or the end-of-line marker.
  typedef struct packed {
    logic       action;
    logic [7:0] char_in;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] op_code;
    logic [7:0] char_out;
    logic       is_literal;
    logic       part_start;
    logic [1:0] error_code;
    logic       last;
  } out_t;

  localparam int unsigned MAX_RES = 4;
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);
  localparam int unsigned SLOT_W  = $clog2(MAX_RES);

  // All results caused by one input transaction, in stream order.
  typedef struct packed {
    logic [CNT_W-1:0]      cnt;
    out_t [MAX_RES-1:0]    slot;
  } bundle_t;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Input actions.
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Result kinds.
  localparam logic [2:0] K_CHAR     = 3'd0;
  localparam logic [2:0] K_EMPTYLIT = 3'd1;
  localparam logic [2:0] K_WEND     = 3'd2;
  localparam logic [2:0] K_OP       = 3'd3;
  localparam logic [2:0] K_END      = 3'd4;
  localparam logic [2:0] K_ERR      = 3'd5;

  // Operator codes.
  localparam logic [3:0] OP_PIPE    = 4'd0;
  localparam logic [3:0] OP_OR      = 4'd1;
  localparam logic [3:0] OP_AND     = 4'd2;
  localparam logic [3:0] OP_BG      = 4'd3;
  localparam logic [3:0] OP_SEMI    = 4'd4;
  localparam logic [3:0] OP_OUT     = 4'd5;
  localparam logic [3:0] OP_APPEND  = 4'd6;
  localparam logic [3:0] OP_IN      = 4'd7;
  localparam logic [3:0] OP_ERR     = 4'd8;
  localparam logic [3:0] OP_ERRAPP  = 4'd9;
  localparam logic [3:0] OP_ALL     = 4'd10;
  localparam logic [3:0] OP_ALLAPP  = 4'd11;

  // Error codes.
  localparam logic [1:0] E_SQUOTE   = 2'd0;
  localparam logic [1:0] E_DQUOTE   = 2'd1;
  localparam logic [1:0] E_SUBST    = 2'd2;
  localparam logic [1:0] E_OVERFLOW = 2'd3;

  // Bytes with a meaning to the lexer.
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;

  // Builds one result with the last flag clear.
  function automatic out_t mk_res(logic [2:0] kind, logic [3:0] op, logic [7:0] ch,
                                  logic lit, logic ps, logic [1:0] err);
    out_t r;
    r.kind       = kind;
    r.op_code    = op;
    r.char_out   = ch;
    r.is_literal = lit;
    r.part_start = ps;
    r.error_code = err;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

/* hdl/sclu_front.sv */
// Front end of the lexer: accepts bytes, updates the lexer state and builds
// the bundle of results for each transaction. Depends on sclu_pkg.
module sclu_front import sclu_pkg::*; #(
  parameter int unsigned NEST_BITS = 8
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    take,
  input  in_t     item,
  output logic    push,
  output bundle_t bundle
);

  typedef enum logic [2:0] {
    M_BETWEEN, M_WORD, M_SQUOTE, M_DQUOTE, M_COMMENT
  } mode_t;

  typedef enum logic [3:0] {
    P_NONE, P_BAR, P_AMP, P_AMPGT, P_GT, P_TWO, P_TWOGT, P_BSLW, P_BSLD, P_DOLLAR
  } pend_t;

  localparam logic [NEST_BITS-1:0] DEPTH_MAX = {NEST_BITS{1'b1}};

  mode_t                mode_r, mode_nxt;
  pend_t                pend_r, pend_nxt;
  logic [NEST_BITS-1:0] depth_r, depth_nxt;
  logic                 nonempty_r, nonempty_nxt;
  logic                 exp_r, exp_nxt;
  logic                 qstart_r, qstart_nxt;
  logic                 ovf_r, ovf_nxt;

  logic [CNT_W-1:0]     n_nxt;
  out_t [MAX_RES-1:0]   slot_nxt;
  logic [7:0]           c;
  logic                 ad;
  logic                 cont;
  logic                 run_word;
  logic                 run_sep;
  logic                 quoting;

  assign c = item.char_in;

  // Next lexer state and the results of this transaction.
  always_comb begin
    mode_nxt     = mode_r;
    pend_nxt     = pend_r;
    depth_nxt    = depth_r;
    nonempty_nxt = nonempty_r;
    exp_nxt      = exp_r;
    qstart_nxt   = qstart_r;
    ovf_nxt      = ovf_r;
    n_nxt        = '0;
    slot_nxt     = '0;
    ad           = 1'b0;
    cont         = 1'b1;
    run_word     = 1'b0;
    run_sep      = 1'b0;
    quoting      = (c == CH_SQUOTE) || (c == CH_DQUOTE) || (c == CH_BSL);

    if (item.action == ACT_END) begin
      // End marker: an error result if one is found, else flush lookahead, the open word and the end token.
      if (ovf_r) begin
        slot_nxt[0] = mk_res(K_ERR, '0, '0, 1'b0, 1'b0, E_OVERFLOW);
        n_nxt = CNT_W'(1);
      end else if (mode_r == M_SQUOTE) begin
        slot_nxt[0] = mk_res(K_ERR, '0, '0, 1'b0, 1'b0, E_SQUOTE);
        n_nxt = CNT_W'(1);
      end else if (mode_r == M_DQUOTE) begin
        slot_nxt[0] = mk_res(K_ERR, '0, '0, 1'b0, 1'b0, E_DQUOTE);
        n_nxt = CNT_W'(1);
      end else if (depth_r != '0) begin
        slot_nxt[0] = mk_res(K_ERR, '0, '0, 1'b0, 1'b0, E_SUBST);
        n_nxt = CNT_W'(1);
      end else begin
        unique case (pend_r)
          P_BAR, P_AMP, P_AMPGT, P_GT, P_TWOGT: begin
            unique case (pend_r)
              P_BAR:   slot_nxt[0] = mk_res(K_OP, OP_PIPE, '0, 1'b0, 1'b0, '0);
              P_AMP:   slot_nxt[0] = mk_res(K_OP, OP_BG, '0, 1'b0, 1'b0, '0);
              P_AMPGT: slot_nxt[0] = mk_res(K_OP, OP_ALL, '0, 1'b0, 1'b0, '0);
              P_GT:    slot_nxt[0] = mk_res(K_OP, OP_OUT, '0, 1'b0, 1'b0, '0);
              default: slot_nxt[0] = mk_res(K_OP, OP_ERR, '0, 1'b0, 1'b0, '0);
            endcase
            n_nxt = CNT_W'(1);
          end
          P_TWO: begin
            slot_nxt[0] = mk_res(K_CHAR, '0, CH_TWO, 1'b0, !exp_r, '0);
            n_nxt = CNT_W'(1);
            nonempty_nxt = 1'b1;
          end
          default: ;
        endcase
        if (nonempty_nxt) begin
          slot_nxt[n_nxt[SLOT_W-1:0]] = mk_res(K_WEND, '0, '0, 1'b0, 1'b0, '0);
          n_nxt = n_nxt + CNT_W'(1);
        end
        slot_nxt[n_nxt[SLOT_W-1:0]] = mk_res(K_END, '0, '0, 1'b0, 1'b0, '0);
        n_nxt = n_nxt + CNT_W'(1);
      end
      // Every end marker returns the lexer to its reset state.
      mode_nxt     = M_BETWEEN;
      pend_nxt     = P_NONE;
      depth_nxt    = '0;
      nonempty_nxt = 1'b0;
      exp_nxt      = 1'b0;
      qstart_nxt   = 1'b0;
      ovf_nxt      = 1'b0;
    end else begin
      // Resolve any held lookahead against this byte.
      pend_nxt = P_NONE;
      unique case (pend_r)
        P_BAR: begin
          if (c == CH_BAR) begin
            slot_nxt[0] = mk_res(K_OP, OP_OR, '0, 1'b0, 1'b0, '0);
            cont = 1'b0;
          end else begin
            slot_nxt[0] = mk_res(K_OP, OP_PIPE, '0, 1'b0, 1'b0, '0);
          end
          n_nxt = CNT_W'(1);
        end
        P_AMP: begin
          if (c == CH_AMP) begin
            slot_nxt[0] = mk_res(K_OP, OP_AND, '0, 1'b0, 1'b0, '0);
            n_nxt = CNT_W'(1);
            cont = 1'b0;
          end else if (c == CH_GT) begin
            pend_nxt = P_AMPGT;
            cont = 1'b0;
          end else begin
            slot_nxt[0] = mk_res(K_OP, OP_BG, '0, 1'b0, 1'b0, '0);
            n_nxt = CNT_W'(1);
          end
        end
        P_AMPGT: begin
          if (c == CH_GT) begin
            slot_nxt[0] = mk_res(K_OP, OP_ALLAPP, '0, 1'b0, 1'b0, '0);
            cont = 1'b0;
          end else begin
            slot_nxt[0] = mk_res(K_OP, OP_ALL, '0, 1'b0, 1'b0, '0);
          end
          n_nxt = CNT_W'(1);
        end
        P_GT: begin
          if (c == CH_GT) begin
            slot_nxt[0] = mk_res(K_OP, OP_APPEND, '0, 1'b0, 1'b0, '0);
            cont = 1'b0;
          end else begin
            slot_nxt[0] = mk_res(K_OP, OP_OUT, '0, 1'b0, 1'b0, '0);
          end
          n_nxt = CNT_W'(1);
        end
        P_TWO: begin
          if (c == CH_GT) begin
            pend_nxt = P_TWOGT;
            cont = 1'b0;
          end else begin
            mode_nxt = M_WORD;
            slot_nxt[0] = mk_res(K_CHAR, '0, CH_TWO, 1'b0, !exp_nxt, '0);
            n_nxt = CNT_W'(1);
            exp_nxt = 1'b1;
            nonempty_nxt = 1'b1;
          end
        end
        P_TWOGT: begin
          if (c == CH_GT) begin
            slot_nxt[0] = mk_res(K_OP, OP_ERRAPP, '0, 1'b0, 1'b0, '0);
            cont = 1'b0;
          end else begin
            slot_nxt[0] = mk_res(K_OP, OP_ERR, '0, 1'b0, 1'b0, '0);
          end
          n_nxt = CNT_W'(1);
        end
        P_BSLW: begin
          slot_nxt[0] = mk_res(K_CHAR, '0, c, 1'b1, 1'b1, '0);
          n_nxt = CNT_W'(1);
          exp_nxt = 1'b0;
          nonempty_nxt = 1'b1;
          cont = 1'b0;
        end
        P_BSLD: begin
          if ((c == CH_DQUOTE) || (c == CH_BSL) || (c == CH_DOLLAR)) begin
            slot_nxt[0] = mk_res(K_CHAR, '0, c, 1'b1, 1'b1, '0);
            exp_nxt = 1'b0;
            cont = 1'b0;
          end else begin
            // The backslash stands for itself; the byte is handled as usual.
            slot_nxt[0] = mk_res(K_CHAR, '0, CH_BSL, 1'b0, !exp_nxt, '0);
            exp_nxt = 1'b1;
          end
          n_nxt = CNT_W'(1);
          nonempty_nxt = 1'b1;
        end
        P_DOLLAR: ad = 1'b1;
        default: ;
      endcase

      // Dispatch the byte by lexer mode.
      if (cont) begin
        unique case (mode_nxt)
          M_BETWEEN: begin
            case (c) inside
              CH_SP, CH_TAB, CH_HASH, CH_NL, CH_SEMI, CH_BAR, CH_AMP, CH_GT, CH_LT,
              CH_TWO: run_sep = 1'b1;
              default: begin
                mode_nxt = M_WORD;
                run_word = 1'b1;
                ad = 1'b0;
              end
            endcase
          end
          M_WORD: run_word = 1'b1;
          M_SQUOTE: begin
            if (c == CH_SQUOTE) begin
              if (!qstart_nxt) begin
                slot_nxt[n_nxt[SLOT_W-1:0]] = mk_res(K_EMPTYLIT, '0, '0, 1'b1, 1'b1, '0);
                n_nxt = n_nxt + CNT_W'(1);
              end
              mode_nxt = M_WORD;
            end else begin
              slot_nxt[n_nxt[SLOT_W-1:0]] = mk_res(K_CHAR, '0, c, 1'b1, !qstart_nxt, '0);
              n_nxt = n_nxt + CNT_W'(1);
              qstart_nxt = 1'b1;
            end
            nonempty_nxt = 1'b1;
          end
          M_DQUOTE: begin
            if (c == CH_DQUOTE) begin
              mode_nxt = M_WORD;
            end else if (c == CH_BSL) begin
              pend_nxt = P_BSLD;
            end else begin
              slot_nxt[n_nxt[SLOT_W-1:0]] = mk_res(K_CHAR, '0, c, 1'b0, !exp_nxt, '0);
              n_nxt = n_nxt + CNT_W'(1);
              exp_nxt = 1'b1;
              nonempty_nxt = 1'b1;
            end
          end
          default: ;
        endcase

        // Inside a word: substitutions, quotes, escapes and word ends.
        if (run_word) begin
          if (c == CH_DOLLAR) begin
            slot_nxt[n_nxt[SLOT_W-1:0]] = mk_res(K_CHAR, '0, c, 1'b0, !exp_nxt, '0);
            n_nxt = n_nxt + CNT_W'(1);
            exp_nxt = 1'b1;
            nonempty_nxt = 1'b1;
            pend_nxt = P_DOLLAR;
          end else if (((depth_nxt != '0) && !quoting) || ((c == CH_LPAREN) && ad)) begin
            if (c == CH_LPAREN) begin
              if (depth_nxt == DEPTH_MAX) begin
                ovf_nxt = 1'b1;
              end else begin
                depth_nxt = depth_nxt + NEST_BITS'(1);
              end
            end else if (c == CH_RPAREN) begin
              depth_nxt = depth_nxt - NEST_BITS'(1);
            end
            slot_nxt[n_nxt[SLOT_W-1:0]] = mk_res(K_CHAR, '0, c, 1'b0, !exp_nxt, '0);
            n_nxt = n_nxt + CNT_W'(1);
            exp_nxt = 1'b1;
            nonempty_nxt = 1'b1;
          end else if (c == CH_SQUOTE) begin
            mode_nxt = M_SQUOTE;
            qstart_nxt = 1'b0;
            exp_nxt = 1'b0;
          end else if (c == CH_DQUOTE) begin
            mode_nxt = M_DQUOTE;
          end else if (c == CH_BSL) begin
            pend_nxt = P_BSLW;
          end else begin
            case (c) inside
              CH_SP, CH_TAB, CH_NL, CH_BAR, CH_AMP, CH_SEMI, CH_GT, CH_LT: begin
                if (nonempty_nxt) begin
                  slot_nxt[n_nxt[SLOT_W-1:0]] = mk_res(K_WEND, '0, '0, 1'b0, 1'b0, '0);
                  n_nxt = n_nxt + CNT_W'(1);
                end
                nonempty_nxt = 1'b0;
                exp_nxt = 1'b0;
                mode_nxt = M_BETWEEN;
                run_sep = 1'b1;
              end
              default: begin
                slot_nxt[n_nxt[SLOT_W-1:0]] = mk_res(K_CHAR, '0, c, 1'b0, !exp_nxt, '0);
                n_nxt = n_nxt + CNT_W'(1);
                exp_nxt = 1'b1;
                nonempty_nxt = 1'b1;
              end
            endcase
          end
        end

        // Between words: blanks, comments and operator starts.
        if (run_sep) begin
          case (c) inside
            CH_HASH: mode_nxt = M_COMMENT;
            CH_NL, CH_SEMI: begin
              slot_nxt[n_nxt[SLOT_W-1:0]] = mk_res(K_OP, OP_SEMI, '0, 1'b0, 1'b0, '0);
              n_nxt = n_nxt + CNT_W'(1);
            end
            CH_LT: begin
              slot_nxt[n_nxt[SLOT_W-1:0]] = mk_res(K_OP, OP_IN, '0, 1'b0, 1'b0, '0);
              n_nxt = n_nxt + CNT_W'(1);
            end
            CH_BAR: pend_nxt = P_BAR;
            CH_AMP: pend_nxt = P_AMP;
            CH_GT:  pend_nxt = P_GT;
            CH_TWO: pend_nxt = P_TWO;
            default: ;
          endcase
        end
      end
    end
  end

  // Place the last flag on the final result of the bundle.
  always_comb begin
    bundle.cnt  = n_nxt;
    bundle.slot = slot_nxt;
    if (n_nxt != '0) begin
      bundle.slot[SLOT_W'(n_nxt - CNT_W'(1))].last = 1'b1;
    end
  end

  assign push = take && (n_nxt != '0);

  // Lexer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_BETWEEN;
      pend_r     <= P_NONE;
      depth_r    <= '0;
      nonempty_r <= 1'b0;
      exp_r      <= 1'b0;
      qstart_r   <= 1'b0;
      ovf_r      <= 1'b0;
    end else if (take) begin
      mode_r     <= mode_nxt;
      pend_r     <= pend_nxt;
      depth_r    <= depth_nxt;
      nonempty_r <= nonempty_nxt;
      exp_r      <= exp_nxt;
      qstart_r   <= qstart_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

endmodule

/* hdl/sclu_queue.sv */
// Short queue of result bundles between the front and back ends.
// Depends on sclu_pkg.
module sclu_queue import sclu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output logic    full,
  output logic    nonempty,
  output bundle_t head
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

  bundle_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_r;
  logic [PTR_W-1:0]    rd_r;
  logic [CNT_QW-1:0]   cnt_r;

  assign full     = (cnt_r == CNT_QW'(QUEUE_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rd_r];

  // Storage: written at the tail.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wr_r <= (wr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      end
      if (pop && nonempty) begin
        rd_r <= (rd_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + CNT_QW'(push && !full) - CNT_QW'(pop && nonempty);
    end
  end

endmodule

/* hdl/sclu_back.sv */
// Back end: holds one bundle and hands its results out one transaction at a
// time. Depends on sclu_pkg.
module sclu_back import sclu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_nonempty,
  input  bundle_t q_head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_stall,
  output out_t    out_data
);

  bundle_t           bun_r;
  logic [SLOT_W-1:0] idx_r;
  logic              busy_r;
  logic              done;
  logic              sent;

  assign out_valid = busy_r;
  assign out_data  = bun_r.slot[idx_r];
  assign sent      = busy_r && !out_stall;
  assign done      = sent && (CNT_W'(idx_r) == bun_r.cnt - CNT_W'(1));
  assign pop       = q_nonempty && (!busy_r || done);

  // Bundle register, slot index and busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (sent) begin
      idx_r <= idx_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bun_r <= q_head;
    end
  end

endmodule

/* hdl/shell_command_lexer_unit.sv */
// Top level of the shell command lexer unit.
// Depends on sclu_pkg, sclu_front, sclu_queue and sclu_back.
//
// The unit takes one byte, or an end-of-line marker, per transaction and may
// accept a new one every clock cycle: the lexer state updates in the cycle of
// acceptance. Each transaction yields zero to three results. They pass
// through a two-bundle queue to an output stage that presents one result per
// cycle while out_stall is low. A transaction's first result is written to the
// queue on acceptance and moves to the output stage register once that stage
// is free. The input stalls only while the queue holds two bundles, so with no
// output stall the sustained rate is one input transaction per cycle while the
// line yields at most one result per byte, and otherwise follows the number of
// results. Errors appear as a single result at the end marker.
module shell_command_lexer_unit import sclu_pkg::*; #(
  parameter int unsigned NEST_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic    take;
  logic    push;
  bundle_t bundle;
  logic    q_full;
  logic    q_nonempty;
  bundle_t q_head;
  logic    pop;

  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;

  // Classification and state update.
  sclu_front #(.NEST_BITS(NEST_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .item   (in_data),
    .push   (push),
    .bundle (bundle)
  );

  // Decoupling queue.
  sclu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (bundle),
    .pop       (pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  // Result serialiser.
  sclu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

`ifndef SYNTH
  // The queue is never pushed while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full)) else $error("bundle pushed into a full queue");

  // An end token or an error always closes its transaction's results.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.kind == K_END) || (out_data.kind == K_ERR))
    |-> out_data.last) else $error("end or error result not marked last");

  // Nothing is presented in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result presented after reset");
`endif

endmodule
